[src/suffix_automaton_distinct_substrings_macros.svh]
// ----------------------------------------------------------------------------
// Suffix automaton assertion macros
// Concurrent assertion shorthands used by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef SUFFIX_AUTOMATON_DISTINCT_SUBSTRINGS_MACROS_SVH
`define SUFFIX_AUTOMATON_DISTINCT_SUBSTRINGS_MACROS_SVH

// same-cycle implication, disabled during reset
`define SA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sa_pkg.sv]
// ----------------------------------------------------------------------------
// Suffix automaton package
// Fixed field widths and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sa_pkg;

  localparam int SYM_W     = 5;
  localparam int NEW_W     = 11;
  localparam int TOT_W     = 20;
  localparam int ROOT_NODE = 1;

endpackage

`default_nettype wire

[src/sa_if.sv]
// ----------------------------------------------------------------------------
// Suffix automaton stream interfaces
// Valid/ready channels for the symbol input and the count result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sa_in_if;
  import sa_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             start_new;

  modport source (output valid, output symbol, output start_new, input ready);
  modport sink   (input valid, input symbol, input start_new, output ready);
endinterface

interface sa_out_if;
  import sa_pkg::*;

  logic             valid;
  logic             ready;
  logic [NEW_W-1:0] new_substrings;
  logic [TOT_W-1:0] total_distinct;
  logic             overflow;

  modport source (output valid, output new_substrings, output total_distinct,
                  output overflow, input ready);
  modport sink   (input valid, input new_substrings, input total_distinct,
                  input overflow, output ready);
endinterface

`default_nettype wire

[src/sa_trans_mem.sv]
// ----------------------------------------------------------------------------
// Suffix automaton transition memory
// One write port, one registered read port; entry is the target node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sa_trans_mem #(
  parameter int ADDR_W = 17,
  parameter int DATA_W = 12
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

[src/sa_node_mem.sv]
// ----------------------------------------------------------------------------
// Suffix automaton node memory
// Length, suffix link and transition-present mask per node; the root lives
// in flip-flops so that reset and a new string clear it at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sa_node_mem #(
  parameter int NODE_W   = 12,
  parameter int LEN_W    = 11,
  parameter int ALPHABET = 26
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                rd_en_i,
  input  logic [NODE_W-1:0]   rd_addr_i,
  output logic [LEN_W-1:0]    rd_len_o,
  output logic [NODE_W-1:0]   rd_link_o,
  output logic [ALPHABET-1:0] rd_mask_o,
  input  logic                wr_en_i,
  input  logic [NODE_W-1:0]   wr_addr_i,
  input  logic [LEN_W-1:0]    wr_len_i,
  input  logic [NODE_W-1:0]   wr_link_i,
  input  logic [ALPHABET-1:0] wr_mask_i
);
  import sa_pkg::*;

  localparam int WORD_W = LEN_W + NODE_W + ALPHABET;

  logic [WORD_W-1:0]   mem [2**NODE_W];
  logic [WORD_W-1:0]   rd_q;
  logic                rd_root_q;
  logic [ALPHABET-1:0] root_mask_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_len_i, wr_link_i, wr_mask_i};
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_mask_q <= '0;
      rd_root_q   <= 1'b0;
    end else begin
      if (clear_i) begin
        root_mask_q <= '0;
      end else if (wr_en_i && wr_addr_i == NODE_W'(ROOT_NODE)) begin
        root_mask_q <= wr_mask_i;
      end
      if (rd_en_i) begin
        rd_root_q <= (rd_addr_i == NODE_W'(ROOT_NODE));
      end
    end
  end

  always_comb begin
    if (rd_root_q) begin
      rd_len_o  = '0;
      rd_link_o = '0;
      rd_mask_o = root_mask_q;
    end else begin
      rd_len_o  = rd_q[WORD_W-1 -: LEN_W];
      rd_link_o = rd_q[ALPHABET +: NODE_W];
      rd_mask_o = rd_q[ALPHABET-1:0];
    end
  end

endmodule

`default_nettype wire

[src/suffix_automaton_distinct_substrings.sv]
// ----------------------------------------------------------------------------
// Suffix automaton distinct substring counter
// Online suffix automaton construction with per-symbol substring counts.
// ----------------------------------------------------------------------------
// Takes one symbol per transfer and returns one result per symbol: the number
// of new distinct substrings ending at it, the running total, and an overflow
// flag once MAX_LEN symbols have been taken. A refused or out-of-alphabet
// symbol goes straight to the output state. An extension walks the suffix
// links, reading each node with its transition, until it passes the root or
// meets an existing transition; a clone copies the target's row of ALPHABET
// transitions and then redirects transitions along the walk. A result that
// waits for the sink holds the block for as long. A new symbol is taken only
// once the last result is in the output register. The node and transition
// memories have one read and one write port each. Neither memory is cleared:
// a per-node mask marks the transitions present, and the root node sits in
// flip-flops, so the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "suffix_automaton_distinct_substrings_macros.svh"

module suffix_automaton_distinct_substrings #(
  parameter int MAX_LEN  = 1024,
  parameter int ALPHABET = 26
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sa_in_if.sink    in_i,
  sa_out_if.source out_o
);
  import sa_pkg::*;

  localparam int NODE_W = $clog2(2 * MAX_LEN + 1);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int AW     = $clog2(ALPHABET);
  localparam int CW     = $clog2(ALPHABET + 1);
  localparam int TA_W   = NODE_W + AW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WRD  = 4'd1;
  localparam logic [3:0] S_WCHK = 4'd2;
  localparam logic [3:0] S_TCHK = 4'd3;
  localparam logic [3:0] S_CLT  = 4'd4;
  localparam logic [3:0] S_COPY = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_RCHK = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [AW-1:0]       sym_q, sym_d;
  logic [NODE_W-1:0]   walk_q, walk_d, last_q, last_d, count_q, count_d;
  logic [NODE_W-1:0]   fresh_q, fresh_d, fresh_link_q, fresh_link_d;
  logic [NODE_W-1:0]   target_q, target_d, twin_q, twin_d;
  logic [LEN_W-1:0]    fresh_len_q, fresh_len_d, len_walk_q, len_walk_d;
  logic [LEN_W-1:0]    len_tgt_q, len_tgt_d, up_len_q, up_len_d;
  logic [LEN_W-1:0]    strlen_q, strlen_d;
  logic [ALPHABET-1:0] mask_tgt_q, mask_tgt_d;
  logic                first_q, first_d;
  logic [CW-1:0]       cp_q, cp_d;
  logic [TOT_W-1:0]    total_q, total_d;
  logic [NEW_W-1:0]    res_new_q, res_new_d;
  logic                res_ovf_q, res_ovf_d;
  logic                out_valid_q, out_valid_d;
  logic [NEW_W-1:0]    out_new_q, out_new_d;
  logic [TOT_W-1:0]    out_tot_q, out_tot_d;
  logic                out_ovf_q, out_ovf_d;

  logic                nd_clear, nd_rd_en, nd_wr_en;
  logic [NODE_W-1:0]   nd_rd_addr, nd_wr_addr, nd_wr_link, nd_link;
  logic [LEN_W-1:0]    nd_wr_len, nd_len;
  logic [ALPHABET-1:0] nd_wr_mask, nd_mask, sym_bit;
  logic                tr_rd_en, tr_wr_en;
  logic [TA_W-1:0]     tr_rd_addr, tr_wr_addr;
  logic [NODE_W-1:0]   tr_rd_data, tr_wr_data;

  logic                sym_ok;
  logic [NODE_W-1:0]   base_last, base_count, twin_new;
  logic [LEN_W-1:0]    base_strlen, diff;
  logic [CW-1:0]       cp_m1;

  sa_node_mem #(
    .NODE_W  (NODE_W),
    .LEN_W   (LEN_W),
    .ALPHABET(ALPHABET)
  ) u_node_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (nd_clear),
    .rd_en_i  (nd_rd_en),
    .rd_addr_i(nd_rd_addr),
    .rd_len_o (nd_len),
    .rd_link_o(nd_link),
    .rd_mask_o(nd_mask),
    .wr_en_i  (nd_wr_en),
    .wr_addr_i(nd_wr_addr),
    .wr_len_i (nd_wr_len),
    .wr_link_i(nd_wr_link),
    .wr_mask_i(nd_wr_mask)
  );

  sa_trans_mem #(
    .ADDR_W(TA_W),
    .DATA_W(NODE_W)
  ) u_trans_mem (
    .clk_i    (clk_i),
    .rd_en_i  (tr_rd_en),
    .rd_addr_i(tr_rd_addr),
    .rd_data_o(tr_rd_data),
    .wr_en_i  (tr_wr_en),
    .wr_addr_i(tr_wr_addr),
    .wr_data_i(tr_wr_data)
  );

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.new_substrings = out_new_q;
  assign out_o.total_distinct = out_tot_q;
  assign out_o.overflow       = out_ovf_q;

  assign sym_ok      = (32'(in_i.symbol) < ALPHABET);
  assign base_last   = in_i.start_new ? NODE_W'(ROOT_NODE) : last_q;
  assign base_count  = in_i.start_new ? NODE_W'(ROOT_NODE) : count_q;
  assign base_strlen = in_i.start_new ? '0 : strlen_q;
  assign sym_bit     = {{(ALPHABET-1){1'b0}}, 1'b1} << sym_q;
  assign twin_new    = count_q + NODE_W'(1);
  assign diff        = fresh_len_q - up_len_q;
  assign cp_m1       = cp_q - CW'(1);

  always_comb begin
    state_d      = state_q;
    sym_d        = sym_q;
    walk_d       = walk_q;
    last_d       = last_q;
    count_d      = count_q;
    fresh_d      = fresh_q;
    fresh_link_d = fresh_link_q;
    target_d     = target_q;
    twin_d       = twin_q;
    fresh_len_d  = fresh_len_q;
    len_walk_d   = len_walk_q;
    len_tgt_d    = len_tgt_q;
    up_len_d     = up_len_q;
    strlen_d     = strlen_q;
    mask_tgt_d   = mask_tgt_q;
    first_d      = first_q;
    cp_d         = cp_q;
    total_d      = total_q;
    res_new_d    = res_new_q;
    res_ovf_d    = res_ovf_q;
    out_valid_d  = out_valid_q;
    out_new_d    = out_new_q;
    out_tot_d    = out_tot_q;
    out_ovf_d    = out_ovf_q;

    nd_clear   = 1'b0;
    nd_rd_en   = 1'b0;
    nd_rd_addr = walk_q;
    nd_wr_en   = 1'b0;
    nd_wr_addr = walk_q;
    nd_wr_len  = nd_len;
    nd_wr_link = nd_link;
    nd_wr_mask = nd_mask;
    tr_rd_en   = 1'b0;
    tr_rd_addr = {walk_q, sym_q};
    tr_wr_en   = 1'b0;
    tr_wr_addr = {walk_q, sym_q};
    tr_wr_data = fresh_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.start_new) begin
            last_d   = NODE_W'(ROOT_NODE);
            count_d  = NODE_W'(ROOT_NODE);
            strlen_d = '0;
            total_d  = '0;
            nd_clear = 1'b1;
          end
          priority if (!sym_ok) begin
            res_new_d = '0;
            res_ovf_d = 1'b0;
            state_d   = S_OUT;
          end else if (base_strlen == LEN_W'(MAX_LEN)) begin
            res_new_d = '0;
            res_ovf_d = 1'b1;
            state_d   = S_OUT;
          end else begin
            sym_d   = AW'(in_i.symbol);
            walk_d  = base_last;
            fresh_d = base_count + NODE_W'(1);
            count_d = base_count + NODE_W'(1);
            first_d = 1'b1;
            state_d = S_WRD;
          end
        end
      end
      S_WRD: begin
        nd_rd_en = 1'b1;
        tr_rd_en = 1'b1;
        state_d  = S_WCHK;
      end
      S_WCHK: begin
        if (first_q) begin
          fresh_len_d = nd_len + LEN_W'(1);
          first_d     = 1'b0;
        end
        if (!nd_mask[sym_q]) begin
          tr_wr_en   = 1'b1;
          nd_wr_en   = 1'b1;
          nd_wr_mask = nd_mask | sym_bit;
          if (nd_link == '0) begin
            fresh_link_d = NODE_W'(ROOT_NODE);
            up_len_d     = '0;
            state_d      = S_FIN;
          end else begin
            walk_d     = nd_link;
            nd_rd_en   = 1'b1;
            nd_rd_addr = nd_link;
            tr_rd_en   = 1'b1;
            tr_rd_addr = {nd_link, sym_q};
          end
        end else begin
          len_walk_d = nd_len;
          target_d   = tr_rd_data;
          nd_rd_en   = 1'b1;
          nd_rd_addr = tr_rd_data;
          state_d    = S_TCHK;
        end
      end
      S_TCHK: begin
        if (len_walk_q + LEN_W'(1) == nd_len) begin
          fresh_link_d = target_q;
          up_len_d     = nd_len;
          state_d      = S_FIN;
        end else begin
          twin_d       = twin_new;
          count_d      = twin_new;
          nd_wr_en     = 1'b1;
          nd_wr_addr   = twin_new;
          nd_wr_len    = len_walk_q + LEN_W'(1);
          len_tgt_d    = nd_len;
          mask_tgt_d   = nd_mask;
          fresh_link_d = twin_new;
          up_len_d     = len_walk_q + LEN_W'(1);
          state_d      = S_CLT;
        end
      end
      S_CLT: begin
        nd_wr_en   = 1'b1;
        nd_wr_addr = target_q;
        nd_wr_len  = len_tgt_q;
        nd_wr_link = twin_q;
        nd_wr_mask = mask_tgt_q;
        cp_d       = '0;
        state_d    = S_COPY;
      end
      S_COPY: begin
        if (cp_q < CW'(ALPHABET)) begin
          tr_rd_en   = 1'b1;
          tr_rd_addr = {target_q, cp_q[AW-1:0]};
        end
        if (cp_q != '0) begin
          tr_wr_en   = 1'b1;
          tr_wr_addr = {twin_q, cp_m1[AW-1:0]};
          tr_wr_data = tr_rd_data;
        end
        if (cp_q == CW'(ALPHABET)) begin
          state_d = S_RRD;
        end else begin
          cp_d = cp_q + CW'(1);
        end
      end
      S_RRD: begin
        nd_rd_en = 1'b1;
        tr_rd_en = 1'b1;
        state_d  = S_RCHK;
      end
      S_RCHK: begin
        if (nd_mask[sym_q] && tr_rd_data == target_q) begin
          tr_wr_en   = 1'b1;
          tr_wr_data = twin_q;
          if (nd_link != '0) begin
            walk_d     = nd_link;
            nd_rd_en   = 1'b1;
            nd_rd_addr = nd_link;
            tr_rd_en   = 1'b1;
            tr_rd_addr = {nd_link, sym_q};
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        nd_wr_en   = 1'b1;
        nd_wr_addr = fresh_q;
        nd_wr_len  = fresh_len_q;
        nd_wr_link = fresh_link_q;
        nd_wr_mask = '0;
        last_d     = fresh_q;
        strlen_d   = strlen_q + LEN_W'(1);
        res_new_d  = NEW_W'(diff);
        res_ovf_d  = 1'b0;
        total_d    = total_q + TOT_W'(diff);
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_new_d   = res_new_q;
          out_tot_d   = total_q;
          out_ovf_d   = res_ovf_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= NODE_W'(ROOT_NODE);
      count_q     <= NODE_W'(ROOT_NODE);
      strlen_q    <= '0;
      total_q     <= '0;
      first_q     <= 1'b0;
      cp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      count_q     <= count_d;
      strlen_q    <= strlen_d;
      total_q     <= total_d;
      first_q     <= first_d;
      cp_q        <= cp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q        <= sym_d;
    walk_q       <= walk_d;
    fresh_q      <= fresh_d;
    fresh_link_q <= fresh_link_d;
    target_q     <= target_d;
    twin_q       <= twin_d;
    fresh_len_q  <= fresh_len_d;
    len_walk_q   <= len_walk_d;
    len_tgt_q    <= len_tgt_d;
    up_len_q     <= up_len_d;
    mask_tgt_q   <= mask_tgt_d;
    res_new_q    <= res_new_d;
    res_ovf_q    <= res_ovf_d;
    out_new_q    <= out_new_d;
    out_tot_q    <= out_tot_d;
    out_ovf_q    <= out_ovf_d;
  end

  `SA_ASSERT_IMP(a_node_bound, clk_i, rst_ni, state_q == S_IDLE,
    32'(count_q) <= 2 * 32'(strlen_q) + 1, "node count exceeds automaton bound")
  `SA_ASSERT_IMP(a_last_alloc, clk_i, rst_ni, 1'b1,
    last_q <= count_q && last_q != '0, "last node outside allocated nodes")
  `SA_ASSERT_IMP(a_out_src, clk_i, rst_ni, $rose(out_valid_q),
    $past(state_q) == S_OUT, "result raised outside output state")
  `SA_ASSERT_IMP(a_ovf_zero, clk_i, rst_ni, out_valid_q && out_ovf_q,
    out_new_q == '0, "refused symbol reports new substrings")

endmodule

`default_nettype wire
